// File: rtl/assert_macros.svh
// Assertion helpers, included by rtl/electrode_level_mode_filter.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/elmf_pkg.sv
package elmf_pkg;

  // Default sizes.
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int ELECTRODES_DEF  = 7;

  // Level codes: 0 is no electrode wet, k is electrode k-1.
  localparam int CODE_W    = 3;
  localparam int NUM_CODES = 8;

  // Percentages.
  localparam int                PCT_W   = 7;
  localparam logic [PCT_W-1:0]  PCT_MAX = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_NONE = 7'd0;

  // Register map.
  localparam int         NUM_PCT_REGS = 7;
  localparam int         CFG_IDX_W    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_LAST = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 8'd7;

  localparam logic [PCT_W-1:0] PCT_RESET [NUM_PCT_REGS] =
    '{7'd14, 7'd28, 7'd42, 7'd57, 7'd71, 7'd85, 7'd100};
  localparam logic [PCT_W-1:0] THRESH_RESET = 7'd5;

  // Control from the sequencer to the window unit.
  typedef struct packed {
    logic              wr_en;
    logic [CODE_W-1:0] code;
    logic              start;
  } mode_ctl_t;

  // Status from the window unit.
  typedef struct packed {
    logic              will_fill;
    logic              done;
    logic [CODE_W-1:0] mode;
  } mode_stat_t;

  // Percentages above 100 report as 100.
  function automatic logic [PCT_W-1:0] pct_cap(input logic [PCT_W-1:0] p);
    pct_cap = (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

endpackage

// File: rtl/elmf_mode_scan.sv
// Ring window of level codes with a histogram-and-pick mode scan.
module elmf_mode_scan #(
  parameter int WINDOW_SIZE = elmf_pkg::WINDOW_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  elmf_pkg::mode_ctl_t    ctl,
  output elmf_pkg::mode_stat_t   stat
);
  import elmf_pkg::*;

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_SIZE);
  localparam logic [CNT_W-1:0]  CNT_ALMOST = CNT_W'(WINDOW_SIZE - 1);
  localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(NUM_CODES - 1);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_HIST = 4'b0010,
    M_PICK = 4'b0100,
    M_DONE = 4'b1000
  } mstate_t;

  mstate_t           state_r, state_nxt;
  logic [CODE_W-1:0] window_r [WINDOW_SIZE];
  logic [IDX_W-1:0]  slot_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  counts_r [NUM_CODES];
  logic [IDX_W-1:0]  idx_r;
  logic [CODE_W-1:0] cand_r;
  logic [CODE_W-1:0] best_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [CODE_W-1:0] cnt_addr;
  logic [CNT_W-1:0]  cnt_rd;

  // One histogram read port, shared by both scan phases.
  assign cnt_addr = (state_r == M_HIST) ? window_r[idx_r] : cand_r;
  assign cnt_rd   = counts_r[cnt_addr];

  assign stat.will_fill = (fill_r >= CNT_ALMOST);
  assign stat.done      = (state_r == M_DONE);
  assign stat.mode      = best_r;

  // Scan sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE: begin
        if (ctl.start) state_nxt = M_HIST;
      end
      M_HIST: begin
        if (idx_r == IDX_LAST) state_nxt = M_PICK;
      end
      M_PICK: begin
        if (cand_r == CODE_LAST) state_nxt = M_DONE;
      end
      M_DONE: begin
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // Window write and ring pointer.
      if (ctl.wr_en) begin
        window_r[slot_r] <= ctl.code;
        slot_r <= (slot_r == IDX_LAST) ? '0 : slot_r + 1'b1;
        if (fill_r != CNT_FULL) fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Histogram build and the running maximum; ties go to the higher code.
  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (ctl.start) begin
          for (int i = 0; i < NUM_CODES; i++) begin
            counts_r[i] <= '0;
          end
          idx_r <= '0;
        end
      end
      M_HIST: begin
        counts_r[cnt_addr] <= cnt_rd + 1'b1;
        idx_r <= idx_r + 1'b1;
        cand_r     <= '0;
        best_r     <= '0;
        best_cnt_r <= '0;
      end
      M_PICK: begin
        if (cnt_rd != '0 && cnt_rd >= best_cnt_r) begin
          best_r     <= cand_r;
          best_cnt_r <= cnt_rd;
        end
        cand_r <= cand_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/electrode_level_mode_filter.sv
// Electrode level mode filter. Each input beat carries one sample of the tank
// electrodes with link-up, measurement-due and force flags. Every measurement
// enters an eight-slot (WINDOW_SIZE) ring window. A measurement whose force flag
// is pending is reported at once with was_forced set: the beat goes straight to
// the emit state, and in_tready stays low until the output register is loaded,
// which waits while the result register is still held by the receiver. Once the
// window is full, an unforced measurement runs a shared counter-and-compare unit
// that builds a histogram over the window one slot per cycle and then picks the
// most frequent level one code per cycle. Such a beat keeps in_tready low through
// the histogram build, the pick, a handover state, a compare state and an emit
// state. The emit state is skipped when the change is below the threshold, and
// it waits while the result register is held. A beat that measures nothing, or
// an unforced measurement before the window is full, leaves in_tready high, so
// the next beat can follow at once. Percent registers and the change threshold
// are written through the cfg port, which is always ready; write them only
// while the block is idle.
module electrode_level_mode_filter #(
  parameter int WINDOW_SIZE = elmf_pkg::WINDOW_SIZE_DEF,
  parameter int ELECTRODES  = elmf_pkg::ELECTRODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] electrode_wet, [7] link_up, [8] measure_due,
                                  // [9] force_request, [15:10] zero
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] level_percent, [7] zero
  output logic        out_tuser,  // [0] was_forced
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [elmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [elmf_pkg::PCT_W-1:0]     cfg_data
);
  import elmf_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MODE = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PCT_W-1:0]   pct_r [NUM_PCT_REGS];
  logic [PCT_W-1:0]   thresh_r;
  logic               fp_r, link_was_r, once_r;
  logic [PCT_W-1:0]   last_r;
  logic [PCT_W-1:0]   value_r;
  logic               forced_r;
  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_forced_r;

  logic               in_acc;
  logic [6:0]         wet;
  logic               link, due, fp_new, measure;
  logic [CODE_W-1:0]  code, pct_code;
  logic [PCT_W-1:0]   pct_sel, diff;
  logic               emit_ok, out_load;
  mode_ctl_t          ctl;
  mode_stat_t         stat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wet  = in_tdata[6:0];
  assign link = in_tdata[7];
  assign due  = in_tdata[8];

  // A force request or a rising link latches a pending force.
  assign fp_new  = fp_r || in_tdata[9] || (link && !link_was_r);
  assign measure = link && (due || fp_new);

  // Highest wet electrode among the ones fitted.
  always_comb begin
    code = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < ELECTRODES && wet[i]) code = CODE_W'(i + 1);
    end
  end

  // Single percent lookup, shared by the live sample and the window mode.
  assign pct_code = (state_r == S_MODE) ? stat.mode : code;
  assign pct_sel  = (pct_code == '0) ? PCT_NONE : pct_cap(pct_r[pct_code - 1'b1]);

  // Window unit control.
  assign ctl.wr_en = in_acc && measure;
  assign ctl.code  = code;
  assign ctl.start = in_acc && measure && !fp_new && stat.will_fill;

  elmf_mode_scan #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .stat (stat)
  );

  // Change check against the last published value.
  assign diff    = (value_r >= last_r) ? value_r - last_r : last_r - value_r;
  assign emit_ok = !once_r || (diff >= thresh_r);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && measure) begin
          if (fp_new)              state_nxt = S_EMIT;
          else if (stat.will_fill) state_nxt = S_MODE;
        end
      end
      S_MODE: begin
        if (stat.done) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = emit_ok ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= 1'b0;
      link_was_r  <= 1'b0;
      once_r      <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      thresh_r    <= THRESH_RESET;
      for (int i = 0; i < NUM_PCT_REGS; i++) begin
        pct_r[i] <= PCT_RESET[i];
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        link_was_r <= link;
        fp_r       <= fp_new && !measure;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESH) begin
          thresh_r <= cfg_data;
        end else if (cfg_index <= REG_PCT_LAST) begin
          pct_r[cfg_index[CODE_W-1:0]] <= cfg_data;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        last_r      <= value_r;
        once_r      <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result value and the output register.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      value_r  <= pct_sel;
      forced_r <= fp_new;
    end else if (state_r == S_MODE && stat.done) begin
      value_r  <= pct_sel;
      forced_r <= 1'b0;
    end
    if (out_load) begin
      out_pct_r    <= value_r;
      out_forced_r <= forced_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pct_r};
  assign out_tuser  = out_forced_r;

  // A reported percentage never exceeds full scale.
  `ASSERT_CLK(a_pct_range, out_tvalid |-> (out_tdata[6:0] <= PCT_MAX), "percent above 100")
  // The mode result arrives only while the sequencer waits for it.
  `ASSERT_CLK(a_done_in_mode, stat.done |-> (state_r == S_MODE), "mode done out of sequence")
  // A beat with the link down measures nothing and leaves the block idle.
  `ASSERT_CLK(a_link_down_idle, (in_acc && !in_tdata[7]) |=> (state_r == S_IDLE),
              "link-down beat started work")

endmodule

// File: verif/electrode_level_mode_filter_tb.sv
module electrode_level_mode_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import elmf_pkg::*;

  localparam int WIN           = WINDOW_SIZE_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_STALL    = 400;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_ITEMS  = 130;
  localparam logic [CODE_W-1:0]    CODE_NONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = REG_THRESH + 8'd1;

  // One sensor sample, packed the way in_tdata carries it.
  typedef struct packed {
    logic       force_req;
    logic       due;
    logic       link;
    logic [6:0] wet;
  } sample_t;

  // One level report, as out_tuser and out_tdata carry it.
  typedef struct packed {
    logic             forced;
    logic [PCT_W-1:0] pct;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PCT_W-1:0]     cfg_data = '0;

  electrode_level_mode_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Stimulus and scoreboard state.
  sample_t samples_to_send [$];
  report_t due_reports [$];
  sample_t in_flight;
  int      idle_pct = 0;
  int      long_stall_reqs = 0;
  int      tank_level = 0;
  int      mismatches = 0;
  int      samples_sent = 0;
  int      reports_seen = 0;
  int      forced_seen = 0;
  int      reg_writes = 0;

  // Mirror of the block's registers and filter state.
  logic [PCT_W-1:0]  reg_file [NUM_PCT_REGS + 1];
  logic [CODE_W-1:0] lvl_window [WIN];
  int                next_slot = 0;
  int                slots_filled = 0;
  logic [PCT_W-1:0]  last_pct = '0;
  logic              has_reported = 1'b0;
  logic              force_latched = 1'b0;
  logic              link_prev = 1'b0;

  initial begin
    for (int i = 0; i < NUM_PCT_REGS; i++) reg_file[i] = PCT_RESET[i];
    reg_file[REG_THRESH] = THRESH_RESET;
    for (int i = 0; i < WIN; i++) lvl_window[i] = CODE_NONE;
  end

  // Percentage for a level code; none reads as zero and large settings clip at 100.
  function automatic logic [PCT_W-1:0] level_pct(input logic [CODE_W-1:0] code);
    if (code == CODE_NONE) return PCT_NONE;
    return (reg_file[code - 1] > PCT_MAX) ? PCT_MAX : reg_file[code - 1];
  endfunction

  // Advance the filter mirror by one accepted sample and queue any report it causes.
  task automatic measure_level(input sample_t s);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] best;
    logic [PCT_W-1:0]  val;
    logic              forced;
    int                tally [NUM_CODES];
    int                best_n;
    int                diff;
    report_t           rep;
    if (s.force_req) force_latched = 1'b1;
    if (s.link && !link_prev) force_latched = 1'b1;
    link_prev = s.link;
    if (!s.link) return;
    forced = force_latched;
    if (!s.due && !forced) return;

    code = CODE_NONE;
    for (int i = 0; i < ELECTRODES_DEF; i++) if (s.wet[i]) code = CODE_W'(i + 1);
    lvl_window[next_slot] = code;
    next_slot = (next_slot + 1) % WIN;
    if (slots_filled < WIN) slots_filled++;

    if (forced) begin
      val = level_pct(code);
    end else if (slots_filled == WIN) begin
      // Most frequent level wins; a tie goes to the higher level.
      for (int i = 0; i < NUM_CODES; i++) tally[i] = 0;
      for (int i = 0; i < WIN; i++) tally[lvl_window[i]]++;
      best = CODE_NONE;
      best_n = 0;
      for (int i = 0; i < NUM_CODES; i++) begin
        if (tally[i] > 0 && tally[i] >= best_n) begin
          best_n = tally[i];
          best = CODE_W'(i);
        end
      end
      val = level_pct(best);
    end else begin
      return;
    end
    force_latched = 1'b0;

    if (!forced) begin
      diff = int'(val) - int'(last_pct);
      if (diff < 0) diff = -diff;
      if (has_reported && diff < int'(reg_file[REG_THRESH])) return;
    end
    last_pct = val;
    has_reported = 1'b1;
    rep.forced = forced;
    rep.pct = val;
    due_reports.push_back(rep);
  endtask

  // Input driver: one beat at a time from the pending queue, with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        measure_level(in_flight);
        samples_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          in_flight = samples_to_send.pop_front();
          in_tdata <= {6'd0, in_flight};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  int recv_stall = 0;
  int stall_reqs_seen = 0;
  always @(posedge clk) begin
    report_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (out_tuser === 1'b1) forced_seen++;
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected report pct %0d forced %0b", $realtime,
                     out_tdata[6:0], out_tuser);
        end else begin
          want = due_reports.pop_front();
          if (out_tdata !== {1'b0, want.pct} || out_tuser !== want.forced) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: report %0d expected pct %0d forced %0b, got data 0x%0h forced %0b",
                       $realtime, reports_seen, want.pct, want.forced, out_tdata, out_tuser);
          end
        end
      end
      if (stall_reqs_seen != long_stall_reqs) begin
        stall_reqs_seen = long_stall_reqs;
        recv_stall = LONG_STALL;
      end else if (recv_stall == 0 && $urandom_range(0, 99) < idle_pct) begin
        recv_stall = $urandom_range(1, 13);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Register write over the cfg channel; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_THRESH) reg_file[idx] = val;
    reg_writes++;
  endtask

  task automatic queue_sample(input logic [6:0] wet, input logic link, input logic due,
                              input logic force_req);
    sample_t s;
    s.wet = wet;
    s.link = link;
    s.due = due;
    s.force_req = force_req;
    samples_to_send.push_back(s);
  endtask

  // Mostly plausible readings around a slowly drifting water level, some pure noise.
  function automatic sample_t random_sample();
    sample_t s;
    int      step;
    if ($urandom_range(0, 99) < 12) begin
      s = 10'($urandom_range(0, 1023));
      return s;
    end
    if ($urandom_range(0, 19) == 0) begin
      tank_level = $urandom_range(0, ELECTRODES_DEF);
    end else if ($urandom_range(0, 4) == 0) begin
      step = $urandom_range(0, 2) - 1;
      tank_level = tank_level + step;
      if (tank_level < 0) tank_level = 0;
      if (tank_level > ELECTRODES_DEF) tank_level = ELECTRODES_DEF;
    end
    s.link = ($urandom_range(0, 24) != 0);
    s.due = ($urandom_range(0, 9) < 7);
    s.force_req = ($urandom_range(0, 14) == 0);
    s.wet = '0;
    if (tank_level != 0) begin
      s.wet = 7'($urandom_range(0, 127)) & (7'h7F >> (ELECTRODES_DEF - tank_level));
      s.wet[tank_level - 1] = 1'b1;
    end
    return s;
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) samples_to_send.push_back(random_sample());
  endtask

  // Hold the sender until every queued sample is in and every report is out,
  // then give the block time to finish work that reports nothing.
  task automatic wait_for_quiet();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || in_tvalid || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. Directed walk: force while the link is down, link rising,
    // window filling, a tie between two levels, and the mode moving.
    idle_pct = 25;
    queue_sample(7'h7F, 1'b0, 1'b1, 1'b1);
    queue_sample(7'h7F, 1'b0, 1'b1, 1'b0);
    queue_sample(7'h01, 1'b1, 1'b0, 1'b0);
    queue_sample(7'h00, 1'b1, 1'b1, 1'b0);
    queue_sample(7'h7F, 1'b1, 1'b0, 1'b1);
    queue_sample(7'h40, 1'b1, 1'b0, 1'b0);
    repeat (5) queue_sample(7'h55, 1'b1, 1'b1, 1'b0);
    repeat (4) queue_sample(7'h04, 1'b1, 1'b1, 1'b0);
    queue_sample(7'h06, 1'b1, 1'b1, 1'b0);
    queue_sample(7'h00, 1'b0, 1'b1, 1'b0);
    queue_sample(7'h00, 1'b1, 1'b0, 1'b0);
    queue_sample(7'h7F, 1'b1, 1'b1, 1'b1);
    repeat (3) queue_sample(7'h20, 1'b1, 1'b1, 1'b0);
    queue_sample(7'h02, 1'b1, 1'b1, 1'b0);
    queue_sample(7'h08, 1'b1, 1'b0, 1'b1);
    queue_sample(7'h10, 1'b1, 1'b1, 1'b1);
    queue_random(RANDOM_ITEMS);
    wait_for_quiet();

    // Levels at both ends of the range and a zero threshold.
    idle_pct = 10;
    for (int i = 0; i <= REG_PCT_LAST; i++)
      write_reg(CFG_IDX_W'(i), (i % 2) ? PCT_MAX : PCT_NONE);
    write_reg(REG_THRESH, 7'd0);
    queue_random(RANDOM_ITEMS);
    wait_for_quiet();

    // Levels above 100 must clip; a threshold no change can reach.
    idle_pct = 40;
    for (int i = 0; i <= REG_PCT_LAST; i++)
      write_reg(CFG_IDX_W'(i), PCT_W'($urandom_range(101, 127)));
    write_reg(REG_THRESH, 7'h7F);
    write_reg(IDX_UNMAPPED, 7'd0);
    queue_random(RANDOM_ITEMS);
    wait_for_quiet();

    // Fully random levels with a small threshold; writes to unmapped indexes.
    idle_pct = 20;
    for (int i = 0; i <= REG_PCT_LAST; i++)
      write_reg(CFG_IDX_W'(i), PCT_W'($urandom_range(0, 127)));
    write_reg(REG_THRESH, PCT_W'($urandom_range(0, 20)));
    write_reg(CFG_IDX_W'($urandom_range(IDX_UNMAPPED, 255)), PCT_W'($urandom_range(0, 127)));
    write_reg('1, 7'h7F);
    queue_random(RANDOM_ITEMS);
    wait_for_quiet();

    // Receiver holds off for a long stretch while forced reports pile up.
    idle_pct = 15;
    for (int i = 0; i <= REG_PCT_LAST; i++)
      write_reg(CFG_IDX_W'(i), PCT_W'($urandom_range(0, 100)));
    write_reg(REG_THRESH, THRESH_RESET);
    long_stall_reqs++;
    repeat (30) queue_sample(7'($urandom_range(0, 127)), 1'b1, 1'($urandom_range(0, 1)), 1'b1);
    queue_random(RANDOM_ITEMS - 30);
    wait_for_quiet();

    // Back to the reset levels, both sides always ready.
    idle_pct = 0;
    for (int i = 0; i <= REG_PCT_LAST; i++) write_reg(CFG_IDX_W'(i), PCT_RESET[i]);
    write_reg(REG_THRESH, PCT_W'($urandom_range(1, 10)));
    queue_random(RANDOM_ITEMS);
    wait_for_quiet();

    $display("Run covered %0d samples over six register settings, %0d register writes.",
             samples_sent, reg_writes);
    $display("Reports checked: %0d (%0d forced), mismatches: %0d.",
             reports_seen, forced_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 8);
    $display("Timeout with %0d samples queued and %0d reports outstanding.",
             samples_to_send.size(), due_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
